// File: src/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared opcodes and controller state type for the supersequence block.
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam logic [1:0] OP_APPEND_A = 2'd0;
   localparam logic [1:0] OP_APPEND_B = 2'd1;
   localparam logic [1:0] OP_START    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_DRAIN,
      ST_WALK_RD,
      ST_WALK_DEC
   } state_type;

endpackage

// File: src/scs_if.sv
// ----------------------------------------------------------------------------
// scs_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] symbol;

   modport source (output valid, output opcode, output symbol, input ready);
   modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

interface scs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_symbol;
   logic       last_symbol;
   logic       no_symbol;
   logic       overflow;

   modport source (output valid, output out_symbol, output last_symbol,
                   output no_symbol, output overflow, input ready);
   modport sink   (input valid, input out_symbol, input last_symbol,
                   input no_symbol, input overflow, output ready);
endinterface

// File: src/scs_cell.sv
// ----------------------------------------------------------------------------
// scs_cell
// One column of the LCS array: holds a second-string symbol, computes one
// table entry per row passing through, and keeps the traceback decisions.
// ----------------------------------------------------------------------------
module scs_cell #(
   parameter int MAX_LEN = 32,
   parameter int SW      = 8,
   parameter int RW      = 5,
   parameter int LW      = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          active,
   input  logic          clear,
   input  logic          load_en,
   input  logic [SW-1:0] load_sym,
   input  logic          in_valid,
   input  logic [SW-1:0] in_sym,
   input  logic [RW-1:0] in_row,
   input  logic [LW-1:0] in_right,
   input  logic [LW-1:0] in_diag,
   output logic          out_valid,
   output logic [SW-1:0] out_sym,
   output logic [RW-1:0] out_row,
   output logic [LW-1:0] out_right,
   output logic [LW-1:0] out_diag,
   input  logic [RW-1:0] rd_addr,
   output logic [SW-1:0] col_sym,
   output logic          dec_match,
   output logic          dec_ge
);

   logic [SW-1:0] sym_ff;
   logic [LW-1:0] below_ff;
   logic          valid_ff;
   logic [SW-1:0] a_ff;
   logic [RW-1:0] row_ff;
   logic [LW-1:0] right_ff;
   logic [LW-1:0] diag_ff;
   logic [1:0]    dec_ff;
   logic [1:0]    mem [MAX_LEN];

   logic          match;
   logic          ge;
   logic [LW-1:0] value;

   always_comb begin
      match = (in_sym == sym_ff);
      ge    = (below_ff >= in_right);
      if (!active) begin
         value = '0;
      end else if (match) begin
         value = in_diag + LW'(1);
      end else begin
         value = ge ? below_ff : in_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         below_ff <= '0;
      end else begin
         valid_ff <= in_valid;
         if (clear) begin
            below_ff <= '0;
         end else if (in_valid) begin
            below_ff <= value;
         end
      end
      if (load_en) begin
         sym_ff <= load_sym;
      end
      a_ff     <= in_sym;
      row_ff   <= in_row;
      right_ff <= value;
      diag_ff  <= below_ff;
   end

   // decision store: {match, below >= right} per row
   always_ff @(posedge clock) begin
      if (in_valid && active) begin
         mem[in_row] <= {match, ge};
      end
      dec_ff <= mem[rd_addr];
   end

   assign out_valid = valid_ff;
   assign out_sym   = a_ff;
   assign out_row   = row_ff;
   assign out_right = right_ff;
   assign out_diag  = diag_ff;
   assign col_sym   = sym_ff;
   assign dec_match = dec_ff[1];
   assign dec_ge    = dec_ff[0];

endmodule

// File: src/shortest_common_supersequence_top.sv
// ----------------------------------------------------------------------------
// shortest_common_supersequence_top
// Shortest common supersequence of two loaded strings, built on a systolic
// row of LCS cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one word per cycle while idle: opcode append-to-first,
//   append-to-second or start, plus a symbol. Appends give no response;
//   an append to a full string is dropped and sets overflow.
//   A start fills the LCS array: rows of the first string enter the cell
//   row one per cycle and ripple left one cell per cycle; n is the first
//   length. The walk then reads the decision stores with a registered
//   read and emits one response word per pass through its read and decide
//   states, up to n + m words, the last one flagged. Two empty strings
//   give a single word flagged no_symbol.
//   req_bus.ready is high only while the controller is idle. A stalled
//   rsp_bus holds its word and pauses the walk; the final word may still
//   wait in the output register while new appends are taken.
//   Reset is synchronous: lengths and overflow clear, the controller goes
//   idle and the output register empties. Lengths and overflow also clear
//   when a start is accepted.
// ----------------------------------------------------------------------------
module shortest_common_supersequence_top
   import scs_pkg::*;
#(
   parameter int MAX_LEN      = 32,
   parameter int SYMBOL_WIDTH = 8
) (
   input logic     clock,
   input logic     reset,
   scs_req_if.sink req_bus,
   scs_rsp_if.source rsp_bus
);

   localparam int SW        = (SYMBOL_WIDTH < 8) ? SYMBOL_WIDTH : 8;
   localparam int RW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LW        = $clog2(MAX_LEN + 1);
   localparam int DRAIN_LEN = MAX_LEN + 2;
   localparam int CW        = $clog2(DRAIN_LEN + 1);

   state_type     state_ff, state_in;
   logic [LW-1:0] a_len_ff, a_len_in;
   logic [LW-1:0] b_len_ff, b_len_in;
   logic          ovf_ff, ovf_in;
   logic [LW-1:0] n_run_ff, n_run_in;
   logic [LW-1:0] m_run_ff, m_run_in;
   logic          ovf_run_ff, ovf_run_in;
   logic [LW-1:0] r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [LW-1:0] i_ff, i_in;
   logic [LW-1:0] j_ff, j_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_sym_ff, rsp_sym_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_none_ff, rsp_none_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic          inj_valid_ff;
   logic [RW-1:0] inj_row_ff;
   logic [SW-1:0] a_rd_ff;
   logic [SW-1:0] first_mem [MAX_LEN];

   logic          accept;
   logic          issue;
   logic          clear;
   logic          a_we;
   logic          b_we;
   logic [RW-1:0] a_addr;
   logic [RW-1:0] row_next;
   logic          slot_free;
   logic          ai, bj;
   logic [RW-1:0] jx;

   // chain links: index MAX_LEN is the injection point, cell g drives g
   logic          lk_valid [MAX_LEN+1];
   logic [SW-1:0] lk_sym   [MAX_LEN+1];
   logic [RW-1:0] lk_row   [MAX_LEN+1];
   logic [LW-1:0] lk_right [MAX_LEN+1];
   logic [LW-1:0] lk_diag  [MAX_LEN+1];
   logic [SW-1:0] col_sym  [MAX_LEN];
   logic          dec_match [MAX_LEN];
   logic          dec_ge    [MAX_LEN];

   assign accept    = req_bus.valid && req_bus.ready;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign row_next  = RW'(r_ff - LW'(1));
   assign ai        = (i_ff < n_run_ff);
   assign bj        = (j_ff < m_run_ff);
   assign jx        = j_ff[RW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         a_len_ff     <= '0;
         b_len_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         inj_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_len_ff     <= a_len_in;
         b_len_ff     <= b_len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         inj_valid_ff <= issue;
      end
      n_run_ff    <= n_run_in;
      m_run_ff    <= m_run_in;
      ovf_run_ff  <= ovf_run_in;
      r_ff        <= r_in;
      cnt_ff      <= cnt_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_last_ff <= rsp_last_in;
      rsp_none_ff <= rsp_none_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      inj_row_ff  <= row_next;
   end

   // first string store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (a_we) begin
         first_mem[a_len_ff[RW-1:0]] <= req_bus.symbol[SW-1:0];
      end
      a_rd_ff <= first_mem[a_addr];
   end

   always_comb begin
      state_in     = state_ff;
      a_len_in     = a_len_ff;
      b_len_in     = b_len_ff;
      ovf_in       = ovf_ff;
      n_run_in     = n_run_ff;
      m_run_in     = m_run_ff;
      ovf_run_in   = ovf_run_ff;
      r_in         = r_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_sym_in   = rsp_sym_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      issue        = 1'b0;
      clear        = 1'b0;
      a_we         = 1'b0;
      b_we         = 1'b0;
      a_addr       = i_ff[RW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_bus.opcode)
                  OP_APPEND_A: begin
                     if (a_len_ff < LW'(MAX_LEN)) begin
                        a_we     = 1'b1;
                        a_len_in = a_len_ff + LW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_APPEND_B: begin
                     if (b_len_ff < LW'(MAX_LEN)) begin
                        b_we     = 1'b1;
                        b_len_in = b_len_ff + LW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_START: begin
                     clear      = 1'b1;
                     n_run_in   = a_len_ff;
                     m_run_in   = b_len_ff;
                     ovf_run_in = ovf_ff;
                     r_in       = a_len_ff;
                     i_in       = '0;
                     j_in       = '0;
                     a_len_in   = '0;
                     b_len_in   = '0;
                     ovf_in     = 1'b0;
                     state_in   = (a_len_ff != '0) ? ST_FILL : ST_WALK_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            // feed rows bottom-up, one per cycle
            issue  = 1'b1;
            a_addr = row_next;
            r_in   = r_ff - LW'(1);
            if (r_ff == LW'(1)) begin
               cnt_in   = CW'(DRAIN_LEN);
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_DEC;
         end
         ST_WALK_DEC: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_ovf_in   = ovf_run_ff;
               rsp_none_in  = 1'b0;
               if (ai && bj) begin
                  if (dec_match[jx]) begin
                     rsp_sym_in = a_rd_ff;
                     i_in       = i_ff + LW'(1);
                     j_in       = j_ff + LW'(1);
                  end else if (dec_ge[jx]) begin
                     rsp_sym_in = a_rd_ff;
                     i_in       = i_ff + LW'(1);
                  end else begin
                     rsp_sym_in = col_sym[jx];
                     j_in       = j_ff + LW'(1);
                  end
               end else if (ai) begin
                  rsp_sym_in = a_rd_ff;
                  i_in       = i_ff + LW'(1);
               end else if (bj) begin
                  rsp_sym_in = col_sym[jx];
                  j_in       = j_ff + LW'(1);
               end else begin
                  // both strings empty
                  rsp_sym_in  = '0;
                  rsp_none_in = 1'b1;
               end
               rsp_last_in = (i_in >= n_run_ff) && (j_in >= m_run_ff);
               state_in    = rsp_last_in ? ST_IDLE : ST_WALK_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign lk_valid[MAX_LEN] = inj_valid_ff;
   assign lk_sym[MAX_LEN]   = a_rd_ff;
   assign lk_row[MAX_LEN]   = inj_row_ff;
   assign lk_right[MAX_LEN] = '0;
   assign lk_diag[MAX_LEN]  = '0;

   for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
      scs_cell #(
         .MAX_LEN (MAX_LEN),
         .SW      (SW),
         .RW      (RW),
         .LW      (LW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .active    (LW'(g) < m_run_ff),
         .clear     (clear),
         .load_en   (b_we && (b_len_ff == LW'(g))),
         .load_sym  (req_bus.symbol[SW-1:0]),
         .in_valid  (lk_valid[g+1]),
         .in_sym    (lk_sym[g+1]),
         .in_row    (lk_row[g+1]),
         .in_right  (lk_right[g+1]),
         .in_diag   (lk_diag[g+1]),
         .out_valid (lk_valid[g]),
         .out_sym   (lk_sym[g]),
         .out_row   (lk_row[g]),
         .out_right (lk_right[g]),
         .out_diag  (lk_diag[g]),
         .rd_addr   (i_ff[RW-1:0]),
         .col_sym   (col_sym[g]),
         .dec_match (dec_match[g]),
         .dec_ge    (dec_ge[g])
      );
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_symbol  = 8'(rsp_sym_ff);
   assign rsp_bus.last_symbol = rsp_last_ff;
   assign rsp_bus.no_symbol   = rsp_none_ff;
   assign rsp_bus.overflow    = rsp_ovf_ff;

endmodule

// File: src/scs_checker.sv
// ----------------------------------------------------------------------------
// scs_checker
// Port-level checks on the supersequence block, bound to its top level.
// ----------------------------------------------------------------------------
module scs_checker
   import scs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_opcode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_symbol,
   input logic       rsp_last_symbol,
   input logic       rsp_no_symbol
);

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_symbol |-> rsp_last_symbol)
      else $error("empty-run word not marked last");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_symbol |-> rsp_out_symbol == 8'd0)
      else $error("empty-run word carries a symbol");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_START |=> !req_ready)
      else $error("request taken right after start");

endmodule

bind shortest_common_supersequence_top scs_checker u_scs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_opcode      (req_bus.opcode),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_symbol  (rsp_bus.out_symbol),
   .rsp_last_symbol (rsp_bus.last_symbol),
   .rsp_no_symbol   (rsp_bus.no_symbol)
);
